@@ hdl/ptd_pkg.sv @@
// Shared constants for the periodic task tick dispatcher.
package ptd_pkg;

  // Slot storage and the number of slots that are actually visited
  localparam int SLOT_MAX   = 4;
  localparam int TASK_COUNT = 4;
  localparam int SLOT_W     = 2;

  // Countdown and register widths
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 3;

  // Register map: periods first, then first delays
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY0  = 3'd4;

  // Tick queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = 2;

  // Stream widths
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

endpackage

@@ hdl/ptd_front.sv @@
// Front end: accepts input transfers, drops idle ticks, queues real ticks.
module ptd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ptd_pkg::IN_DATA_W-1:0] in_tdata,   // [0] tick, rest zero
  output logic                          q_valid,
  input  logic                          q_pop
);

  logic [ptd_pkg::QCNT_W-1:0] count_r;
  logic [ptd_pkg::QCNT_W-1:0] count_nxt;
  logic                       push;

  // Only a tick of one does any work; a zero tick is taken and dropped
  assign in_tready = (count_r != ptd_pkg::QCNT_W'(ptd_pkg::QUEUE_DEPTH));
  assign push      = in_tvalid & in_tready & in_tdata[0];
  assign q_valid   = (count_r != '0);

  // Pending tick count
  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

@@ hdl/ptd_back.sv @@
// Back end: task registers, countdowns and in-order dispatch output.
module ptd_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptd_pkg::CNT_W-1:0]      cfg_wdata,
  input  logic                           q_valid,
  output logic                           q_pop,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ptd_pkg::OUT_DATA_W-1:0] out_tdata,  // [1:0] task_index, rest zero
  output logic                           out_tlast   // last_of_tick
);

  logic [ptd_pkg::CNT_W-1:0]      period_r    [ptd_pkg::SLOT_MAX];
  logic [ptd_pkg::CNT_W-1:0]      countdown_r [ptd_pkg::SLOT_MAX];
  logic [ptd_pkg::TASK_COUNT-1:0] mask_r;
  logic [ptd_pkg::TASK_COUNT-1:0] mask_nxt;
  logic [ptd_pkg::TASK_COUNT-1:0] due;
  logic [ptd_pkg::TASK_COUNT-1:0] rest;
  logic [ptd_pkg::SLOT_W-1:0]     sel;
  logic [ptd_pkg::SLOT_W-1:0]     cfg_slot;
  logic                           out_valid_r;
  logic [ptd_pkg::SLOT_W-1:0]     out_index_r;
  logic                           out_last_r;
  logic                           out_load;
  logic                           wr_period;
  logic                           wr_delay;

  // Register decode: periods sit below the delay block
  assign cfg_slot  = cfg_index[ptd_pkg::SLOT_W-1:0];
  assign wr_delay  = cfg_we && (cfg_index >= ptd_pkg::REG_DELAY0);
  assign wr_period = cfg_we && (cfg_index < ptd_pkg::REG_DELAY0);

  // Start a new tick once the previous one has been fully handed out
  assign q_pop = q_valid && (mask_r == '0);

  // Due slots for the tick being started
  always_comb begin
    for (int i = 0; i < ptd_pkg::TASK_COUNT; i++) begin
      due[i] = (period_r[i] != '0) && (countdown_r[i] == '0);
    end
  end

  // Lowest pending slot wins (slot 0 highest priority)
  always_comb begin
    sel = '0;
    for (int i = ptd_pkg::TASK_COUNT - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        sel = ptd_pkg::SLOT_W'(i);
      end
    end
    rest = mask_r;
    rest[sel] = 1'b0;
  end

  assign out_load = (mask_r != '0) && (!out_valid_r || out_tready);

  always_comb begin
    mask_nxt = mask_r;
    if (q_pop) begin
      mask_nxt = due;
    end else if (out_load) begin
      mask_nxt = rest;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_index_r <= sel;
      out_last_r  <= (rest == '0);
    end
  end

  // Task registers and countdowns: config loads, tick reloads or decrements
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ptd_pkg::SLOT_MAX; i++) begin
        period_r[i]    <= '0;
        countdown_r[i] <= '0;
      end
    end else begin
      if (wr_period) begin
        period_r[cfg_slot] <= cfg_wdata;
      end
      if (wr_delay) begin
        countdown_r[cfg_slot] <= cfg_wdata;
      end else if (q_pop) begin
        for (int i = 0; i < ptd_pkg::TASK_COUNT; i++) begin
          if (period_r[i] != '0) begin
            if (countdown_r[i] == '0) begin
              countdown_r[i] <= period_r[i] - 1'b1;
            end else begin
              countdown_r[i] <= countdown_r[i] - 1'b1;
            end
          end
        end
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(ptd_pkg::OUT_DATA_W - ptd_pkg::SLOT_W)'(0), out_index_r};
  assign out_tlast  = out_last_r;

endmodule

@@ hdl/periodic_task_tick_dispatcher_unit.sv @@
// Top level of the periodic task tick dispatcher.
// First dispatch of a tick: the queue count, then the pending-slot mask, then the output register.
// A tick holds the dispatch stage for its pop from the queue and one output load per due slot;
// the two-entry tick queue keeps the input open while dispatches drain, until it is full.
// Reset (rst_n low, synchronous): periods and countdowns clear, queue and output empty.
module periodic_task_tick_dispatcher_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [ptd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ptd_pkg::CNT_W-1:0]      cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [ptd_pkg::IN_DATA_W-1:0]  in_tdata,   // [0] tick, rest zero
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ptd_pkg::OUT_DATA_W-1:0] out_tdata,  // [1:0] task_index, rest zero
  output logic                           out_tlast   // last_of_tick
);

  logic q_valid;
  logic q_pop;

  // Tick intake and queue
  ptd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  // Countdown update and dispatch
  ptd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hdl/ptd_checker.sv @@
// Port-level checks for the periodic task tick dispatcher, bound to the top level.
module ptd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ptd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // Dispatches of one tick follow back to back in rising slot order
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[1:0] > $past(out_tdata[1:0])))
    else $error("dispatch order broken");

  // The highest slot is always the final dispatch of its tick
  a_top_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == 2'd3) |-> out_tlast)
    else $error("slot 3 not marked last");

endmodule

bind periodic_task_tick_dispatcher_unit ptd_checker u_ptd_checker (.*);
